// ===== sv/sts_pkg.sv =====
package sts_pkg;

    // Scanner modes, one-hot
    typedef enum logic [3:0] {
        MODE_IDLE  = 4'b0001,
        MODE_NUM   = 4'b0010,
        MODE_IDENT = 4'b0100,
        MODE_ERR   = 4'b1000
    } scan_mode_t;

    localparam int KIND_W   = 4;
    localparam int FIELD_W  = 16;
    localparam int KW_COUNT = 4;

    // Token kinds
    localparam logic [KIND_W-1:0] KIND_LBRACE  = 4'd0;
    localparam logic [KIND_W-1:0] KIND_RBRACE  = 4'd1;
    localparam logic [KIND_W-1:0] KIND_AT      = 4'd2;
    localparam logic [KIND_W-1:0] KIND_LPAREN  = 4'd3;
    localparam logic [KIND_W-1:0] KIND_RPAREN  = 4'd4;
    localparam logic [KIND_W-1:0] KIND_IDENT   = 4'd5;
    localparam logic [KIND_W-1:0] KIND_MODEL   = 4'd6;
    localparam logic [KIND_W-1:0] KIND_STRING  = 4'd7;
    localparam logic [KIND_W-1:0] KIND_INTEGER = 4'd8;
    localparam logic [KIND_W-1:0] KIND_BOOLEAN = 4'd9;
    localparam logic [KIND_W-1:0] KIND_NUMBER  = 4'd10;
    localparam logic [KIND_W-1:0] KIND_ERROR   = 4'd11;

    // Keyword spellings, padded with NUL, in the order model, String, Integer, Boolean
    localparam logic [7:0] KW_TEXT [KW_COUNT][8] = '{
        '{"m", "o", "d", "e", "l", 8'h00, 8'h00, 8'h00},
        '{"S", "t", "r", "i", "n", "g", 8'h00, 8'h00},
        '{"I", "n", "t", "e", "g", "e", "r", 8'h00},
        '{"B", "o", "o", "l", "e", "a", "n", 8'h00}
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd5, 3'd6, 3'd7, 3'd7};

    // Result queue geometry
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = 2;
    localparam int CNT_W       = 3;

    typedef struct packed {
        logic                vld;
        logic [KIND_W-1:0]   kind;
        logic [FIELD_W-1:0]  start;
        logic [FIELD_W-1:0]  length;
        logic                last;
    } token_t;

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {["0":"9"]};
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return c inside {["a":"z"], ["A":"Z"]};
    endfunction

    function automatic logic is_ident_char(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == "_");
    endfunction

    // Space, tab, LF, VT, FF, CR
    function automatic logic is_space(input logic [7:0] c);
        return c inside {8'h20, [8'h09:8'h0d]};
    endfunction

    function automatic logic is_symbol(input logic [7:0] c);
        return c inside {"{", "}", "@", "(", ")"};
    endfunction

    function automatic logic [KIND_W-1:0] symbol_kind(input logic [7:0] c);
        logic [KIND_W-1:0] k;
        case (c)
            "{":     k = KIND_LBRACE;
            "}":     k = KIND_RBRACE;
            "@":     k = KIND_AT;
            "(":     k = KIND_LPAREN;
            ")":     k = KIND_RPAREN;
            default: k = KIND_ERROR;
        endcase
        return k;
    endfunction

    // First keyword still matching whose length fits, else plain identifier
    function automatic logic [KIND_W-1:0] ident_kind(input logic [KW_COUNT-1:0] match,
                                                     input logic [KW_COUNT-1:0] len_hit);
        logic [KW_COUNT-1:0] hit;
        hit = match & len_hit;
        if (hit[0])      return KIND_MODEL;
        else if (hit[1]) return KIND_STRING;
        else if (hit[2]) return KIND_INTEGER;
        else if (hit[3]) return KIND_BOOLEAN;
        else             return KIND_IDENT;
    endfunction

endpackage

// ===== sv/sts_lexer.sv =====
module sts_lexer
    import sts_pkg::*;
#(
    parameter int OFFSET_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step_en,
    input  logic [7:0]  source_byte,
    input  logic        end_of_source,
    output token_t      res0,
    output token_t      res1
);

    scan_mode_t                 mode_reg, mode_next, mode_mid;
    logic [OFFSET_BITS-1:0]     offset_reg, offset_next, offset_new;
    logic [OFFSET_BITS-1:0]     start_reg, start_next, start_mid;
    logic [KW_COUNT-1:0]        match_reg, match_next, match_mid;

    logic                       saturated;
    logic [OFFSET_BITS-1:0]     len_a, len_e;
    logic [KW_COUNT-1:0]        hit_a, hit_e, keep, init_match;
    logic                       consumed, close_a, close_e;
    logic                       one_vld;
    logic [KIND_W-1:0]          one_kind, kind_a, kind_e;
    logic [FIELD_W-1:0]         one_len;
    token_t                     tok_a, tok_one, tok_e;

    assign saturated = &offset_reg;
    assign len_a     = offset_reg - start_reg;

    // Per-keyword length checks and running character compare
    always_comb begin
        for (int k = 0; k < KW_COUNT; k++) begin
            hit_a[k]      = (len_a == OFFSET_BITS'(KW_LEN[k]));
            keep[k]       = !saturated && (len_a < OFFSET_BITS'(KW_LEN[k]))
                            && (KW_TEXT[k][len_a[2:0]] == source_byte);
            init_match[k] = (KW_TEXT[k][0] == source_byte);
        end
    end

    assign kind_a = (mode_reg == MODE_NUM) ? KIND_NUMBER : ident_kind(match_reg, hit_a);

    // Continue, close or start a token for this byte
    always_comb begin
        mode_mid  = mode_reg;
        start_mid = start_reg;
        match_mid = match_reg;
        consumed  = 1'b0;
        close_a   = 1'b0;
        one_vld   = 1'b0;
        one_kind  = KIND_ERROR;
        one_len   = '0;
        if (mode_reg != MODE_ERR) begin
            if (mode_reg == MODE_NUM) begin
                consumed = is_digit(source_byte);
                close_a  = !consumed;
            end else if (mode_reg == MODE_IDENT) begin
                consumed = is_ident_char(source_byte);
                close_a  = !consumed;
                if (consumed) begin
                    match_mid = match_reg & keep;
                end
            end
            if (close_a) begin
                mode_mid = MODE_IDLE;
            end
            if (!consumed) begin
                if (is_space(source_byte)) begin
                    one_vld = 1'b0;
                end else if (is_symbol(source_byte)) begin
                    one_vld  = 1'b1;
                    one_kind = symbol_kind(source_byte);
                    one_len  = FIELD_W'(1);
                end else if (is_digit(source_byte)) begin
                    mode_mid  = MODE_NUM;
                    start_mid = offset_reg;
                end else if (is_alpha(source_byte) || source_byte == "_") begin
                    mode_mid  = MODE_IDENT;
                    start_mid = offset_reg;
                    match_mid = init_match;
                end else begin
                    one_vld  = 1'b1;
                    one_kind = KIND_ERROR;
                    mode_mid = MODE_ERR;
                end
            end
        end
    end

    // Advance the offset, holding it at the top of its range
    assign offset_new = saturated ? offset_reg : offset_reg + OFFSET_BITS'(1);

    // Close a token still pending at the end of the source
    assign close_e = end_of_source && (mode_mid == MODE_NUM || mode_mid == MODE_IDENT);
    assign len_e   = offset_new - start_mid;

    always_comb begin
        for (int k = 0; k < KW_COUNT; k++) begin
            hit_e[k] = (len_e == OFFSET_BITS'(KW_LEN[k]));
        end
    end

    assign kind_e = (mode_mid == MODE_NUM) ? KIND_NUMBER : ident_kind(match_mid, hit_e);

    always_comb begin
        tok_a   = '{vld: close_a, kind: kind_a, start: FIELD_W'(start_reg),
                    length: FIELD_W'(len_a), last: 1'b0};
        tok_one = '{vld: one_vld, kind: one_kind, start: FIELD_W'(offset_reg),
                    length: one_len, last: 1'b0};
        tok_e   = '{vld: close_e, kind: kind_e, start: FIELD_W'(start_mid),
                    length: FIELD_W'(len_e), last: 1'b0};
    end

    // Pack results in order: closed token, symbol or error, end-of-source close
    always_comb begin
        res0 = '0;
        res1 = '0;
        if (step_en) begin
            if (tok_a.vld) begin
                res0 = tok_a;
                res1 = tok_one.vld ? tok_one : tok_e;
            end else if (tok_one.vld) begin
                res0 = tok_one;
                res1 = tok_e;
            end else begin
                res0 = tok_e;
            end
        end
        res0.last = res0.vld && !res1.vld;
        res1.last = res1.vld;
    end

    // Next state: back to reset after the last byte of a source, held in error mode, else advanced
    always_comb begin
        if (end_of_source) begin
            mode_next   = MODE_IDLE;
            offset_next = '0;
            start_next  = '0;
            match_next  = '1;
        end else if (mode_reg == MODE_ERR) begin
            mode_next   = mode_reg;
            offset_next = offset_reg;
            start_next  = start_reg;
            match_next  = match_reg;
        end else begin
            mode_next   = mode_mid;
            offset_next = offset_new;
            start_next  = start_mid;
            match_next  = match_mid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            offset_reg <= '0;
            start_reg  <= '0;
            match_reg  <= '1;
        end else if (step_en) begin
            mode_reg   <= mode_next;
            offset_reg <= offset_next;
            start_reg  <= start_next;
            match_reg  <= match_next;
        end
    end

endmodule

// ===== sv/schema_token_scanner.sv =====
// Tokens of a taken item are written into the token queue and offered on m_ from its head.
// One source byte per cycle while s_ready holds; two tokens from one byte leave in turn.
// s_ready holds while the four-entry token queue has room for two tokens.
// Reset (aresetn low, synchronous) empties the queue and returns the scanner to idle
// with offset zero and all keyword matches set.
module schema_token_scanner
    import sts_pkg::*;
#(
    parameter int OFFSET_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_source_byte,
    input  logic                 s_end_of_source,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [KIND_W-1:0]    m_token_kind,
    output logic [FIELD_W-1:0]   m_token_start,
    output logic [FIELD_W-1:0]   m_token_length,
    output logic                 m_last_of_run
);

    token_t                 res0, res1;
    token_t                 queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       push_n;
    logic                   accept, pop;

    assign s_ready = (count_reg <= CNT_W'(QUEUE_DEPTH - 2));
    assign accept  = s_valid && s_ready;
    assign pop     = m_valid && m_ready;

    sts_lexer #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_lexer (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step_en       (accept),
        .source_byte   (s_source_byte),
        .end_of_source (s_end_of_source),
        .res0          (res0),
        .res1          (res1)
    );

    // Queue bookkeeping
    assign push_n      = CNT_W'(res0.vld) + CNT_W'(res1.vld);
    assign wr_ptr_next = wr_ptr_reg + PTR_W'(push_n);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign count_next  = count_reg + push_n - CNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Write up to two tokens per item
    always_ff @(posedge aclk) begin
        if (res0.vld) begin
            queue_reg[wr_ptr_reg] <= res0;
        end
        if (res1.vld) begin
            queue_reg[wr_ptr_reg + PTR_W'(1)] <= res1;
        end
    end

    // Present the oldest token
    assign m_valid        = (count_reg != '0);
    assign m_token_kind   = queue_reg[rd_ptr_reg].kind;
    assign m_token_start  = queue_reg[rd_ptr_reg].start;
    assign m_token_length = queue_reg[rd_ptr_reg].length;
    assign m_last_of_run  = queue_reg[rd_ptr_reg].last;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("token queue overfilled");

    a_packed_results: assert property (@(posedge aclk) disable iff (!aresetn)
        res1.vld |-> res0.vld && res1.last && !res0.last)
        else $error("second token without a first, or wrong end-of-run flag");

    a_push_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_n != '0) |=> m_valid)
        else $error("pushed token not offered");

    a_no_push_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |-> push_n == '0)
        else $error("token produced without an accepted item");

endmodule
